// ===== rtl/core/ipv4_port_text_validator_defines.svh =====
// Assertion macros for the IPv4 address-and-port text checker.
// Included by the top level; the macros expect clk and rst_n in scope.
`ifndef IPV4_PORT_TEXT_VALIDATOR_DEFINES_SVH
`define IPV4_PORT_TEXT_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define IPV4V_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IPV4V_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ipv4v_pkg.sv =====
// Shared types and constants of the IPv4 address-and-port text checker.
// No dependencies; used by ipv4v_parser and ipv4_port_text_validator.
package ipv4v_pkg;

  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_NINE    = 8'h39;
  localparam logic [7:0]  CH_DOT     = 8'h2E;
  localparam logic [7:0]  CH_COLON   = 8'h3A;

  localparam int          ACC_W      = 17;
  localparam int          PROD_W     = 21;
  localparam logic [16:0] ACC_MAX    = 17'h1FFFF;
  localparam logic [16:0] OCTET_MAX  = 17'd255;
  localparam logic [16:0] PORT_MAX   = 17'd65535;

  localparam logic [2:0]  LAST_OCTET = 3'd3;
  localparam logic [2:0]  PORT_PART  = 3'd4;
  localparam logic [1:0]  CNT_MAX    = 2'd2;

  // One character request as it leaves the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
    logic       last_char;
  } item_t;

  // One result request.
  typedef struct packed {
    logic        valid_res;
    logic [7:0]  octet_a;
    logic [7:0]  octet_b;
    logic [7:0]  octet_c;
    logic [7:0]  octet_d;
    logic [15:0] port_number;
  } result_t;

endpackage

// ===== rtl/core/ipv4v_parser.sv =====
// Parse state and per-character update of the IPv4 address-and-port checker.
// Depends on ipv4v_pkg; its result is registered by the top level.
module ipv4v_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  ipv4v_pkg::item_t item,
  output ipv4v_pkg::result_t res
);
  import ipv4v_pkg::*;

  logic [2:0]       part_index_r, part_index_nxt;
  logic [ACC_W-1:0] value_acc_r, value_acc_nxt;
  logic [1:0]       digit_count_r, digit_count_nxt;
  logic             leading_zero_r, leading_zero_nxt;
  logic             error_seen_r, error_seen_nxt;
  logic [7:0]       octet_store_r [4];
  logic [7:0]       octet_store_nxt [4];

  logic              is_digit;
  logic [3:0]        digit;
  logic [PROD_W-1:0] acc_sum;
  logic              close_part;
  logic              ok;

  always_comb begin
    part_index_nxt   = part_index_r;
    value_acc_nxt    = value_acc_r;
    digit_count_nxt  = digit_count_r;
    leading_zero_nxt = leading_zero_r;
    error_seen_nxt   = error_seen_r;
    octet_store_nxt  = octet_store_r;

    is_digit = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
    digit    = item.char_code[3:0];
    // Times ten as two shifted copies, then add the digit.
    acc_sum  = {1'b0, value_acc_r, 3'b000} + {3'b000, value_acc_r, 1'b0}
             + {{(PROD_W-4){1'b0}}, digit};
    close_part = ((item.char_code == CH_DOT) && (part_index_r < LAST_OCTET)) ||
                 ((item.char_code == CH_COLON) && (part_index_r == LAST_OCTET));

    if (is_digit) begin
      if ((digit_count_r != 2'd0) && leading_zero_r) begin
        error_seen_nxt = 1'b1;
      end
      if ((digit_count_r == 2'd0) && (digit == 4'd0)) begin
        leading_zero_nxt = 1'b1;
      end
      value_acc_nxt = (acc_sum > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
      if (digit_count_r < CNT_MAX) begin
        digit_count_nxt = digit_count_r + 2'd1;
      end
    end else if (close_part) begin
      if ((digit_count_r == 2'd0) || (value_acc_r > OCTET_MAX)) begin
        error_seen_nxt = 1'b1;
      end
      octet_store_nxt[part_index_r[1:0]] = value_acc_r[7:0];
      part_index_nxt   = part_index_r + 3'd1;
      value_acc_nxt    = '0;
      digit_count_nxt  = 2'd0;
      leading_zero_nxt = 1'b0;
    end else begin
      // Foreign character or a separator in the wrong place.
      error_seen_nxt = 1'b1;
    end

    ok = !error_seen_nxt && (part_index_nxt == PORT_PART) &&
         (digit_count_nxt != 2'd0) && (value_acc_nxt <= PORT_MAX);

    res.valid_res   = ok;
    res.octet_a     = ok ? octet_store_nxt[0] : 8'd0;
    res.octet_b     = ok ? octet_store_nxt[1] : 8'd0;
    res.octet_c     = ok ? octet_store_nxt[2] : 8'd0;
    res.octet_d     = ok ? octet_store_nxt[3] : 8'd0;
    res.port_number = ok ? value_acc_nxt[15:0] : 16'd0;
  end

  // The state returns to its reset value after the last character of a text.
  always_ff @(posedge clk) begin
    if (!rst_n || (item.valid && item.last_char)) begin
      part_index_r   <= 3'd0;
      value_acc_r    <= '0;
      digit_count_r  <= 2'd0;
      leading_zero_r <= 1'b0;
      error_seen_r   <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        octet_store_r[i] <= 8'd0;
      end
    end else if (item.valid) begin
      part_index_r   <= part_index_nxt;
      value_acc_r    <= value_acc_nxt;
      digit_count_r  <= digit_count_nxt;
      leading_zero_r <= leading_zero_nxt;
      error_seen_r   <= error_seen_nxt;
      octet_store_r  <= octet_store_nxt;
    end
  end

endmodule

// ===== rtl/core/ipv4_port_text_validator.sv =====
// Checks the text "a.b.c.d:e" fed one character per request and reports its form.
// The input channel takes one character per request: in_char_code, with
// in_last_char set on the final character of a text. Only that final character
// causes a result request on the output channel: out_valid_res, the four octets
// and out_port_number, all zero when the text is not well formed.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. A character is taken every cycle while in_stall is low: each
// passes an input register and then parse logic that updates the parse state.
// The result is formed from the input register, loaded into an output register
// and held there until the receiver takes it.
// While a result waits under out_stall, characters that close no text still
// flow; a second last character waits in the input register and in_stall
// rises only then, so at most one result and one character are held.
// Synchronous reset (rst_n low) clears the parse state and both registers'
// valid flags; the block is ready as soon as reset is released.
// After every result the parse state starts afresh for the next text.
module ipv4_port_text_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [7:0]  out_octet_a,
  output logic [7:0]  out_octet_b,
  output logic [7:0]  out_octet_c,
  output logic [7:0]  out_octet_d,
  output logic [15:0] out_port_number
);
  import ipv4v_pkg::*;
  `include "ipv4_port_text_validator_defines.svh"

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    res_r;
  result_t    res_comb;
  item_t      item;
  logic       out_free;
  logic       s1_blocked;
  logic       in_take;
  logic       res_load;

  assign out_free   = !out_valid_r || !out_stall;
  assign s1_blocked = s1_valid_r && s1_last_r && !out_free;
  assign in_stall   = s1_blocked;
  assign in_take    = in_valid && !in_stall;
  assign res_load   = s1_valid_r && s1_last_r && !s1_blocked;

  assign item.valid     = s1_valid_r && !s1_blocked;
  assign item.char_code = s1_char_r;
  assign item.last_char = s1_last_r;

  ipv4v_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .res   (res_comb)
  );

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_blocked) begin
      s1_valid_nxt = s1_valid_r;
    end else begin
      s1_valid_nxt = 1'b0;
    end

    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last_char;
    end
    if (res_load) begin
      res_r <= res_comb;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = res_r.valid_res;
  assign out_octet_a     = res_r.octet_a;
  assign out_octet_b     = res_r.octet_b;
  assign out_octet_c     = res_r.octet_c;
  assign out_octet_d     = res_r.octet_d;
  assign out_port_number = res_r.port_number;

  `IPV4V_ASSERT_NOW(a_stall_only_when_result_held, in_stall, out_valid && out_stall,
                    "input stalled without a held result")
  `IPV4V_ASSERT_NOW(a_invalid_result_zero, out_valid && !out_valid_res,
                    (out_octet_a == 8'd0) && (out_octet_b == 8'd0) &&
                    (out_octet_c == 8'd0) && (out_octet_d == 8'd0) &&
                    (out_port_number == 16'd0),
                    "invalid result carries non-zero fields")
  `IPV4V_ASSERT_NEXT(a_result_drains, out_valid && !out_stall && !res_load, !out_valid,
                     "taken result was not removed")

endmodule
